@@ rtl/md5_pkg.sv @@
// package for the md5 digest block: types, round constants, helpers
`default_nettype none
package md5_pkg;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_ROUND,
        t_ST_FOLD,
        t_ST_PADLEN,
        t_ST_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic       absorb;     // write input byte, bump count
        logic       pad_start;  // write 0x80 at count, clear tail
        logic       clear_blk;  // zero whole block (second pad block)
        logic       put_len;    // write bit length into words 14 and 15
        logic       load_work;  // a..d <= chain
        logic       round;      // one round step
        logic       fold;       // chain += a..d
        logic       init;       // chain and count back to initial values
    } t_cmd;

    // datapath status
    typedef struct packed {
        logic       blk_full;   // count low six bits wrapped to zero after absorb
        logic       pad_two;    // pad position at 56 or above
    } t_stat;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;

    localparam logic [31:0] K_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_TAB [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [5:0] g;
        begin
            case (r[5:4])
                2'd0:    g = r;
                2'd1:    g = 6'(r * 6'd5 + 6'd1);
                2'd2:    g = 6'(r * 6'd3 + 6'd5);
                default: g = 6'(r * 6'd7);
            endcase
            return g[3:0];
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/md5_message_digest_top.sv @@
// md5 message digest top level: stream ports around controller and datapath
`default_nettype none
// Byte-serial MD5 hasher. Each input item carries at most one message byte
// (tuser bit 0 says the byte is present) and tlast ends the message. A byte
// that does not complete a 64-byte block is taken and the hasher stays ready
// for the next item. A byte that completes a block starts the 64-round
// compression: one round per cycle in a single shared round unit, and no
// item is taken until the block is folded into the chain. On the last item
// the padding block is compressed, followed by a second padding block when
// one is needed; a last item whose byte fills a block first compresses that
// block and then a whole padding block. The four digest words go out as four
// result items, word 0 first, tlast on word 3; the hasher then starts over
// with the initial chaining values.
module md5_message_digest_top
    import md5_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] byte_valid
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] digest_word, [33:32] word_index
    output logic             m_axis_tlast
);

    t_cmd         w_cmd;
    t_stat        w_stat;
    logic [5:0]   w_round;
    logic [1:0]   w_widx;
    logic [127:0] w_chain;

    md5_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_byte_valid (s_axis_tuser),
        .i_last       (s_axis_tlast),
        .i_out_ready  (m_axis_tready),
        .i_stat       (w_stat),
        .o_in_ready   (s_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_word_idx   (w_widx),
        .o_cmd        (w_cmd),
        .o_round      (w_round)
    );

    md5_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_round (w_round),
        .i_byte  (s_axis_tdata),
        .o_stat  (w_stat),
        .o_chain (w_chain)
    );

    // digest words held in the chaining registers until the last is taken
    assign m_axis_tdata = {6'd0, w_widx, w_chain[32*w_widx +: 32]};
    assign m_axis_tlast = (w_widx == 2'd3);

endmodule
`default_nettype wire

@@ rtl/md5_datapath.sv @@
// md5 datapath: message block, byte counter, round unit, chaining words
`default_nettype none
module md5_datapath
    import md5_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [5:0]  i_round,
    input  wire logic [7:0]  i_byte,
    output t_stat            o_stat,
    output logic [127:0]     o_chain
);

    logic [31:0] r_blk [16];
    logic [63:0] r_cnt;
    logic [31:0] r_h [4];
    logic [31:0] r_a, r_b, r_c, r_d;

    logic [5:0]  w_pos;
    logic [63:0] w_cnt_inc;
    logic [31:0] w_f, w_t, w_rot;
    logic [4:0]  w_s;
    logic [63:0] w_bits;

    assign w_pos     = r_cnt[5:0];
    assign w_cnt_inc = r_cnt + 64'd1;
    assign w_bits    = {r_cnt[60:0], 3'b000};

    always_comb begin
        case (i_round[5:4])
            2'd0:    w_f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    w_f = (r_b & r_d) | (r_c & ~r_d);
            2'd2:    w_f = r_b ^ r_c ^ r_d;
            default: w_f = r_c ^ (r_b | ~r_d);
        endcase
        w_t   = r_a + w_f + K_TAB[i_round] + r_blk[msg_index(i_round)];
        w_s   = ROT_TAB[{i_round[5:4], i_round[1:0]}];
        w_rot = (w_t << w_s) | (w_t >> (6'd32 - {1'b0, w_s}));
    end

    assign o_stat.blk_full = (w_cnt_inc[5:0] == 6'd0);
    assign o_stat.pad_two  = (w_pos >= 6'd56);
    assign o_chain = {r_h[3], r_h[2], r_h[1], r_h[0]};

    // message block writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.absorb) begin
            r_blk[w_pos[5:2]][8*w_pos[1:0] +: 8] <= i_byte;
        end
        if (i_cmd.pad_start) begin
            for (int i = 0; i < 64; i++) begin
                if (6'(i) == w_pos)
                    r_blk[i/4][8*(i%4) +: 8] <= 8'h80;
                else if (6'(i) > w_pos)
                    r_blk[i/4][8*(i%4) +: 8] <= 8'h00;
            end
        end
        if (i_cmd.clear_blk) begin
            for (int i = 0; i < 16; i++) r_blk[i] <= '0;
        end
        if (i_cmd.put_len) begin
            r_blk[14] <= w_bits[31:0];
            r_blk[15] <= w_bits[63:32];
        end
    end

    // working variables; a fold also leaves the new chain in a..d
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_work) begin
            r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
        end else if (i_cmd.round) begin
            r_a <= r_d; r_d <= r_c; r_c <= r_b; r_b <= r_b + w_rot;
        end else if (i_cmd.fold) begin
            r_a <= r_h[0] + r_a; r_b <= r_h[1] + r_b;
            r_c <= r_h[2] + r_c; r_d <= r_h[3] + r_d;
        end
    end

    // chaining words and byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            r_h[0] <= H0; r_h[1] <= H1; r_h[2] <= H2; r_h[3] <= H3;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.fold) begin
                r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
            end
            if (i_cmd.absorb) r_cnt <= w_cnt_inc;
        end
    end

endmodule
`default_nettype wire

@@ rtl/md5_ctrl.sv @@
// md5 controller: item acceptance, round sequencing, padding and output
`default_nettype none
module md5_ctrl
    import md5_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_byte_valid,
    input  wire logic        i_last,
    input  wire logic        i_out_ready,
    input  wire t_stat       i_stat,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output logic [1:0]       o_word_idx,
    output t_cmd             o_cmd,
    output logic [5:0]       o_round
);

    t_state     r_state, n_state;
    logic [5:0] r_round, n_round;
    logic [1:0] r_widx, n_widx;
    logic       r_fin, n_fin;      // a last item is being finished
    logic       r_two, n_two;      // a second pad block still follows
    logic       r_lpend, n_lpend;  // last came with a block-filling byte, pad after fold
    logic       w_acc;

    assign w_acc      = i_in_valid && o_in_ready;
    assign o_round    = r_round;
    assign o_word_idx = r_widx;

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_widx  = r_widx;
        n_fin   = r_fin;
        n_two   = r_two;
        n_lpend = r_lpend;
        case (r_state)
            t_ST_IDLE: begin
                if (w_acc) begin
                    n_round = '0;
                    if (i_byte_valid && i_stat.blk_full) begin
                        n_fin   = 1'b0;
                        n_lpend = i_last;
                        n_state = t_ST_ROUND;
                    end else if (i_last) begin
                        n_fin   = 1'b1;
                        n_state = t_ST_PADLEN;
                    end
                end
            end
            t_ST_PADLEN: begin
                n_two   = i_stat.pad_two;
                n_state = t_ST_ROUND;
            end
            t_ST_ROUND: begin
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) n_state = t_ST_FOLD;
            end
            t_ST_FOLD: begin
                if (r_lpend) begin
                    n_lpend = 1'b0;
                    n_fin   = 1'b1;
                    n_state = t_ST_PADLEN;
                end else if (!r_fin) begin
                    n_state = t_ST_IDLE;
                end else if (r_two) begin
                    n_two   = 1'b0;
                    n_state = t_ST_ROUND;
                end else begin
                    n_widx  = '0;
                    n_state = t_ST_OUT;
                end
            end
            t_ST_OUT: begin
                if (i_out_ready) begin
                    n_widx = r_widx + 2'd1;
                    if (r_widx == 2'd3) begin
                        n_fin   = 1'b0;
                        n_state = t_ST_IDLE;
                    end
                end
            end
            default: n_state = t_ST_IDLE;
        endcase
    end

    // padlen first writes pad; length written at padlen only when no second
    // block, else at the fold that starts the second block
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            t_ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.absorb     = w_acc && i_byte_valid;
                o_cmd.load_work  = w_acc;
            end
            t_ST_PADLEN: begin
                o_cmd.pad_start = 1'b1;
                o_cmd.put_len   = !i_stat.pad_two;
                o_cmd.load_work = 1'b1;
            end
            t_ST_ROUND: o_cmd.round = 1'b1;
            t_ST_FOLD: begin
                o_cmd.fold = 1'b1;
                if (r_fin && r_two) begin
                    o_cmd.clear_blk = 1'b1;
                    o_cmd.put_len   = 1'b1;
                end
            end
            t_ST_OUT: begin
                o_out_valid = 1'b1;
                o_cmd.init  = i_out_ready && (r_widx == 2'd3);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_ST_IDLE;
            r_round <= '0;
            r_widx  <= '0;
            r_fin   <= 1'b0;
            r_two   <= 1'b0;
            r_lpend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_widx  <= n_widx;
            r_fin   <= n_fin;
            r_two   <= n_two;
            r_lpend <= n_lpend;
        end
    end

endmodule
`default_nettype wire
